@@ src/bsc_pkg.sv @@
// package: calibration types and constants for the barometric compensation pipeline
package bsc_pkg;

   localparam int DIV_BITS = 32;

   localparam logic [31:0] B6_OFFSET = 32'd4000;
   localparam logic [31:0] B4_OFFSET = 32'd32768;
   localparam logic [31:0] B7_SCALE = 32'd50000;
   localparam logic [31:0] P_C1 = 32'd3038;
   localparam logic [31:0] P_C2 = 32'd7357;
   localparam logic [31:0] P_C3 = 32'd3791;

   typedef enum logic [1:0] {
      CSR_CALIB_A = 2'd0,
      CSR_CALIB_B = 2'd1,
      CSR_CALIB_C = 2'd2,
      CSR_OVERSAMPLING = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure_bytes;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_tenths;
      logic signed [31:0] pressure_pa;
      logic divide_error;
   } rsp_type;

   // sign-extended 16-bit field
   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   // arithmetic right shift of a 32-bit pattern
   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
      asr = 32'($signed(v) >>> s);
   endfunction

endpackage

@@ src/bsc_if.sv @@
// interfaces: valid/ready channels for request and response items
interface bsc_req_if;
   import bsc_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bsc_rsp_if;
   import bsc_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/bsc_div.sv @@
// pipelined unsigned restoring divider, one quotient bit per stage, with sideband
module bsc_div #(
   parameter int SideWidth = 8
) (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic in_valid,
   input logic [31:0] in_num,
   input logic [31:0] in_den,
   input logic [SideWidth-1:0] in_side,
   output logic out_valid,
   output logic [31:0] out_quot,
   output logic [SideWidth-1:0] out_side
);
   import bsc_pkg::*;

   logic [DIV_BITS:1] valid_ff;
   logic [31:0] rem_ff [1:DIV_BITS-1];
   logic [31:0] num_ff [1:DIV_BITS];
   logic [31:0] den_ff [1:DIV_BITS-1];
   logic [SideWidth-1:0] side_ff [1:DIV_BITS];

   // operands seen by each stage
   logic [31:0] rem_cur [DIV_BITS];
   logic [31:0] num_cur [DIV_BITS];
   logic [31:0] den_cur [DIV_BITS];
   logic [SideWidth-1:0] side_cur [DIV_BITS];
   logic [31:0] rem_in [DIV_BITS];
   logic [31:0] num_in [DIV_BITS];

   always_comb begin
      rem_cur[0] = '0;
      num_cur[0] = in_num;
      den_cur[0] = in_den;
      side_cur[0] = in_side;
      for (int k = 1; k < DIV_BITS; k++) begin
         rem_cur[k] = rem_ff[k];
         num_cur[k] = num_ff[k];
         den_cur[k] = den_ff[k];
         side_cur[k] = side_ff[k];
      end
   end

   always_comb begin
      logic [32:0] trial;
      logic [32:0] diff;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {rem_cur[k], num_cur[k][31]};
         diff = trial - {1'b0, den_cur[k]};
         if (!diff[32]) begin
            rem_in[k] = diff[31:0];
            num_in[k] = {num_cur[k][30:0], 1'b1};
         end else begin
            rem_in[k] = trial[31:0];
            num_in[k] = {num_cur[k][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DIV_BITS-1:1], in_valid};
      end
      if (advance) begin
         for (int k = 1; k < DIV_BITS; k++) begin
            rem_ff[k] <= rem_in[k-1];
            den_ff[k] <= den_cur[k-1];
         end
         for (int k = 1; k <= DIV_BITS; k++) begin
            num_ff[k] <= num_in[k-1];
            side_ff[k] <= side_cur[k-1];
         end
      end
   end

   assign out_valid = valid_ff[DIV_BITS];
   assign out_quot = num_ff[DIV_BITS];
   assign out_side = side_ff[DIV_BITS];
endmodule

@@ src/baro_sensor_compensation.sv @@
// top level: pipelined barometric temperature and pressure compensation
// One item (a raw temperature and raw pressure pair) enters per cycle and one result
// item leaves per cycle while the result register can take data. The pipeline is made of
// two 32-stage bit-per-stage dividers (temperature term, then pressure quotient) plus
// twelve register stages around them. The whole pipeline moves as one when the result
// register can take data, so a stalled result holds everything behind it without loss.
// Calibration and oversampling are plain registers; the user must write them only while idle (not enforced).
module baro_sensor_compensation (
   input logic clock,
   input logic reset,
   input logic csr_write,
   input logic [1:0] csr_index,
   input logic [63:0] csr_data,
   bsc_req_if.sink req,
   bsc_rsp_if.source rsp
);
   import bsc_pkg::*;

   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0] oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CALIB_A: cal_a_ff <= csr_data;
            CSR_CALIB_B: cal_b_ff <= csr_data;
            CSR_CALIB_C: cal_c_ff <= csr_data[31:0];
            CSR_OVERSAMPLING: oss_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // calibration words
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   always_comb begin
      ac1 = sx16(cal_a_ff[63:48]);
      ac2 = sx16(cal_a_ff[47:32]);
      ac3 = sx16(cal_a_ff[31:16]);
      ac4 = {16'd0, cal_a_ff[15:0]};
      ac5 = {16'd0, cal_b_ff[63:48]};
      ac6 = {16'd0, cal_b_ff[47:32]};
      b1 = sx16(cal_b_ff[31:16]);
      b2 = sx16(cal_b_ff[15:0]);
      mc = sx16(cal_c_ff[31:16]);
      md = sx16(cal_c_ff[15:0]);
   end

   // whole pipeline advances when the output slot is free or being taken
   logic advance;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   // stage 1: up, ut - ac6
   logic v1_ff;
   logic [31:0] up1_ff, d1_ff;
   // stage 2: x1 = (ut-ac6)*ac5 >> 15
   logic v2_ff;
   logic [31:0] up2_ff, x1t2_ff;
   // stage 3: divisor and signed operands for the temperature divide
   logic v3_ff;
   logic [31:0] up3_ff, x1t3_ff, tnum3_ff, tden3_ff;
   logic tneg3_ff, terr3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   logic [31:0] div3_in, mcs3_in;
   always_comb begin
      div3_in = x1t2_ff + md;
      mcs3_in = mc << 11;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         up1_ff <= {8'd0, req.data.raw_pressure_bytes} >> (4'd8 - {2'b00, oss_ff});
         d1_ff <= {16'd0, req.data.raw_temperature} - ac6;
         up2_ff <= up1_ff;
         x1t2_ff <= asr(d1_ff * ac5, 5'd15);
         up3_ff <= up2_ff;
         x1t3_ff <= x1t2_ff;
         tnum3_ff <= mcs3_in[31] ? -mcs3_in : mcs3_in;
         tden3_ff <= div3_in[31] ? -div3_in : div3_in;
         tneg3_ff <= mcs3_in[31] ^ div3_in[31];
         terr3_ff <= (div3_in == '0);
      end
   end

   // temperature divide, sideband carries up, x1, sign, error
   localparam int TSide = 32 + 32 + 1 + 1;
   logic tv_out;
   logic [31:0] tq_out;
   logic [TSide-1:0] tside_out;
   bsc_div #(.SideWidth(TSide)) u_tdiv (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v3_ff), .in_num(tnum3_ff), .in_den(tden3_ff),
      .in_side({up3_ff, x1t3_ff, tneg3_ff, terr3_ff}),
      .out_valid(tv_out), .out_quot(tq_out), .out_side(tside_out)
   );

   // stage 4: b5, t, b6
   logic v4_ff, err4_ff;
   logic [31:0] up4_ff, t4_ff, b64_ff;
   logic [31:0] b5_in;
   always_comb begin
      b5_in = tside_out[33:2] + (tside_out[1] ? -tq_out : tq_out);
   end
   // stage 5: products of b6
   logic v5_ff, err5_ff;
   logic [31:0] up5_ff, t5_ff, b65_ff, sq5_ff, ac2b6_5_ff, ac3b6_5_ff;
   // stage 6: scaled products of sq and b6
   logic v6_ff, err6_ff;
   logic [31:0] up6_ff, t6_ff, x1b_6_ff, x2b_6_ff, x1c_6_ff, x2c_6_ff;
   // stage 7: b3, x3 for b4
   logic v7_ff, err7_ff;
   logic [31:0] up7_ff, t7_ff, b3_7_ff, x3c_7_ff;
   // stage 8: b4 = ac4*(x3+32768)>>15, up-b3
   logic v8_ff, err8_ff;
   logic [31:0] t8_ff, b4_8_ff, ub_8_ff;
   // stage 9: b7
   logic v9_ff, err9_ff;
   logic [31:0] t9_ff, b4_9_ff, b7_9_ff;

   logic [31:0] x3b_in, b3t_in, b3_in;
   always_comb begin
      x3b_in = x1b_6_ff + x2b_6_ff;
      b3t_in = ((ac1 * 32'd4 + x3b_in) << oss_ff) + 32'd2;
      // truncating divide by 4 toward zero
      b3_in = asr(b3t_in + (b3t_in[31] ? 32'd3 : 32'd0), 5'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         {v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff} <= '0;
      end else if (advance) begin
         v4_ff <= tv_out;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err4_ff <= tside_out[0];
         up4_ff <= tside_out[65:34];
         t4_ff <= asr(b5_in + 32'd8, 5'd4);
         b64_ff <= b5_in - B6_OFFSET;

         err5_ff <= err4_ff;
         up5_ff <= up4_ff;
         t5_ff <= t4_ff;
         b65_ff <= b64_ff;
         sq5_ff <= asr(b64_ff * b64_ff, 5'd12);
         ac2b6_5_ff <= ac2 * b64_ff;
         ac3b6_5_ff <= ac3 * b64_ff;

         err6_ff <= err5_ff;
         up6_ff <= up5_ff;
         t6_ff <= t5_ff;
         x1b_6_ff <= asr(b2 * sq5_ff, 5'd11);
         x2b_6_ff <= asr(ac2b6_5_ff, 5'd11);
         x1c_6_ff <= asr(ac3b6_5_ff, 5'd13);
         x2c_6_ff <= asr(b1 * sq5_ff, 5'd16);

         err7_ff <= err6_ff;
         up7_ff <= up6_ff;
         t7_ff <= t6_ff;
         b3_7_ff <= b3_in;
         x3c_7_ff <= asr(x1c_6_ff + x2c_6_ff + 32'd2, 5'd2);

         err8_ff <= err7_ff;
         t8_ff <= t7_ff;
         b4_8_ff <= (ac4 * (x3c_7_ff + B4_OFFSET)) >> 15;
         ub_8_ff <= up7_ff - b3_7_ff;

         err9_ff <= err8_ff || (b4_8_ff == '0);
         t9_ff <= t8_ff;
         b4_9_ff <= b4_8_ff;
         b7_9_ff <= ub_8_ff * (B7_SCALE >> oss_ff);
      end
   end

   // pressure divide: numerator b7*2 or b7, doubled after when b7 top bit set
   localparam int PSide = 32 + 1 + 1;
   logic pv_out;
   logic [31:0] pq_out;
   logic [PSide-1:0] pside_out;
   bsc_div #(.SideWidth(PSide)) u_pdiv (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v9_ff),
      .in_num(b7_9_ff[31] ? b7_9_ff : {b7_9_ff[30:0], 1'b0}),
      .in_den(b4_9_ff),
      .in_side({t9_ff, b7_9_ff[31], err9_ff}),
      .out_valid(pv_out), .out_quot(pq_out), .out_side(pside_out)
   );

   // stage 10: p, p>>8 squared
   logic v10_ff, err10_ff;
   logic [31:0] t10_ff, p10_ff, pp10_ff, m10_ff;
   logic [31:0] p_in, p8_in;
   always_comb begin
      p_in = pside_out[1] ? {pq_out[30:0], 1'b0} : pq_out;
      p8_in = asr(p_in, 5'd8);
   end
   // stage 11: x1, x2
   logic v11_ff, err11_ff;
   logic [31:0] t11_ff, p11_ff, x1p11_ff, x2p11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (advance) begin
         v10_ff <= pv_out;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         err10_ff <= pside_out[0];
         t10_ff <= pside_out[PSide-1:2];
         p10_ff <= p_in;
         pp10_ff <= p8_in * p8_in;
         m10_ff <= P_C2 * p_in;

         err11_ff <= err10_ff;
         t11_ff <= t10_ff;
         p11_ff <= p10_ff;
         x1p11_ff <= asr(pp10_ff * P_C1, 5'd16);
         x2p11_ff <= asr(32'd0 - m10_ff, 5'd16);
      end
   end

   // output register
   rsp_type rsp_in;
   always_comb begin
      rsp_in.divide_error = err11_ff;
      rsp_in.temperature_tenths = err11_ff ? '0 : t11_ff;
      rsp_in.pressure_pa = err11_ff ? '0 :
         p11_ff + asr(x1p11_ff + x2p11_ff + P_C3, 5'd4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v11_ff;
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;
endmodule

@@ tb/baro_sensor_compensation_checker.sv @@
// checker: watches both channels, predicts each compensated reading and compares it
module baro_sensor_compensation_checker (
   input logic clock,
   input logic reset,
   input logic csr_write,
   input logic [1:0] csr_index,
   input logic [63:0] csr_data,
   bsc_req_if req,
   bsc_rsp_if rsp,
   output int fail_count,
   output int pending,
   output int results_seen,
   output int errors_seen
);
   import bsc_pkg::*;

   logic [63:0] calib_a, calib_b;
   logic [31:0] calib_c;
   logic [1:0] osr;
   rsp_type readings_due[$];

   function automatic logic [31:0] shr_signed(input logic [31:0] v, input int s);
      logic signed [31:0] sv;
      sv = v;
      return sv >>> s;
   endfunction

   function automatic logic [31:0] quot_signed(input logic [31:0] a, input logic [31:0] b);
      longint q;
      q = longint'($signed(a)) / longint'($signed(b));
      return q[31:0];
   endfunction

   function automatic rsp_type compensate(input logic [63:0] ga, input logic [63:0] gb,
                                          input logic [31:0] gc, input logic [1:0] os,
                                          input req_type r);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
      logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, t, p, dv;
      rsp_type res;
      ac1 = {{16{ga[63]}}, ga[63:48]};
      ac2 = {{16{ga[47]}}, ga[47:32]};
      ac3 = {{16{ga[31]}}, ga[31:16]};
      ac4 = {16'd0, ga[15:0]};
      ac5 = {16'd0, gb[63:48]};
      ac6 = {16'd0, gb[47:32]};
      b1 = {{16{gb[31]}}, gb[31:16]};
      b2 = {{16{gb[15]}}, gb[15:0]};
      mc = {{16{gc[31]}}, gc[31:16]};
      md = {{16{gc[15]}}, gc[15:0]};
      ut = {16'd0, r.raw_temperature};
      up = {8'd0, r.raw_pressure_bytes} >> (8 - int'(os));
      res = '0;
      res.divide_error = 1'b1;
      x1 = shr_signed((ut - ac6) * ac5, 15);
      dv = x1 + md;
      if (dv == 0) return res;
      x2 = quot_signed(mc << 11, dv);
      b5 = x1 + x2;
      t = shr_signed(b5 + 32'd8, 4);
      b6 = b5 - B6_OFFSET;
      sq = shr_signed(b6 * b6, 12);
      x1 = shr_signed(b2 * sq, 11);
      x2 = shr_signed(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = quot_signed(((ac1 * 32'd4 + x3) << os) + 32'd2, 32'd4);
      x1 = shr_signed(ac3 * b6, 13);
      x2 = shr_signed(b1 * sq, 16);
      x3 = shr_signed(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + B4_OFFSET)) >> 15;
      if (b4 == 0) return res;
      b7 = (up - b3) * (B7_SCALE >> os);
      if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
      else p = (b7 / b4) * 32'd2;
      x1 = shr_signed(p, 8) * shr_signed(p, 8);
      x1 = shr_signed(x1 * P_C1, 16);
      x2 = shr_signed(32'd0 - P_C2 * p, 16);
      p = p + shr_signed(x1 + x2 + P_C3, 4);
      res.temperature_tenths = t;
      res.pressure_pa = p;
      res.divide_error = 1'b0;
      return res;
   endfunction

   assign pending = readings_due.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         calib_a <= '0;
         calib_b <= '0;
         calib_c <= '0;
         osr <= '0;
         readings_due.delete();
         fail_count <= 0;
         results_seen <= 0;
         errors_seen <= 0;
      end else begin
         if (req.valid && req.ready)
            readings_due.push_back(compensate(calib_a, calib_b, calib_c, osr, req.data));
         if (rsp.valid && rsp.ready) begin
            results_seen <= results_seen + 1;
            if (rsp.data.divide_error) errors_seen <= errors_seen + 1;
            if (readings_due.size() == 0) begin
               $display("%0t: result with nothing expected, got %h", $time, rsp.data);
               fail_count <= fail_count + 1;
            end else begin
               want = readings_due.pop_front();
               if (want !== rsp.data) begin
                  $display("%0t: expected temp %0d pres %0d err %b, got temp %0d pres %0d err %b",
                           $time, want.temperature_tenths, want.pressure_pa,
                           want.divide_error, rsp.data.temperature_tenths,
                           rsp.data.pressure_pa, rsp.data.divide_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_CALIB_A: calib_a <= csr_data;
               CSR_CALIB_B: calib_b <= csr_data;
               CSR_CALIB_C: calib_c <= csr_data[31:0];
               CSR_OVERSAMPLING: osr <= csr_data[1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

@@ tb/baro_sensor_compensation_tb.sv @@
// testbench top: stimulus, calibration phases and verdict for the compensation pipeline
module baro_sensor_compensation_tb;
   import bsc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_CALIB_A;
   logic [63:0] csr_data = '0;
   int fail_count, pending, results_seen, errors_seen;
   int items_sent = 0;
   int phase_count = 0;
   bit hold_rsp = 0;     // ask the receiver for one long hold-off
   bit no_idle = 0;      // phases with back-to-back items and no random stalls

   bsc_req_if req ();
   bsc_rsp_if rsp ();

   baro_sensor_compensation DUT (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req(req.sink), .rsp(rsp.source)
   );

   baro_sensor_compensation_checker u_checker (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req(req), .rsp(rsp), .fail_count(fail_count),
      .pending(pending), .results_seen(results_seen), .errors_seen(errors_seen)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver side: random stalls, plus one long hold while the sender keeps going
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            @(posedge clock);
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               @(posedge clock);
               rsp.ready <= 1'b0;
               repeat (n - 1) @(posedge clock);
            end
            @(posedge clock);
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic send_reading(input logic [15:0] ut, input logic [23:0] up);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= '{raw_temperature: ut, raw_pressure_bytes: up};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
   endtask

   // drain every expected result, then let the pipeline settle
   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic load_calibration(input logic [63:0] ga, input logic [63:0] gb,
                                   input logic [31:0] gc, input logic [1:0] os);
      csr_write <= 1'b1;
      csr_index <= CSR_CALIB_A;
      csr_data <= ga;
      @(posedge clock);
      csr_index <= CSR_CALIB_B;
      csr_data <= gb;
      @(posedge clock);
      csr_index <= CSR_CALIB_C;
      csr_data <= {32'd0, gc};
      @(posedge clock);
      csr_index <= CSR_OVERSAMPLING;
      csr_data <= {62'd0, os};
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      phase_count++;
   endtask

   // typical datasheet-like calibration set
   localparam logic [63:0] NOM_A = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
   localparam logic [63:0] NOM_B = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
   localparam logic [31:0] NOM_C = {-16'sd8711, 16'sd2868};

   task automatic random_phase(input int count, input logic [1:0] os, input bit wild);
      logic [63:0] ga, gb;
      logic [31:0] gc;
      logic [15:0] ut;
      if (wild) begin
         ga = {$urandom, $urandom};
         gb = {$urandom, $urandom};
         gc = $urandom;
      end else begin
         ga = NOM_A ^ {48'd0, 16'($urandom_range(0, 255))};
         gb = NOM_B ^ {16'($urandom_range(0, 255)), 48'd0};
         gc = NOM_C ^ 32'($urandom_range(0, 63));
      end
      wait_drained();
      load_calibration(ga, gb, gc, os);
      repeat (count) begin
         // mostly readings near room conditions, the rest full range
         if ($urandom_range(0, 3) != 0) ut = 16'(gb[47:32] + $urandom_range(0, 12000) - 4000);
         else ut = 16'($urandom);
         if ($urandom_range(0, 3) != 0)
            send_reading(ut, 24'(($urandom_range(15000, 45000) << 8) >> (3 - os) << (3 - os)
                              | $urandom_range(0, 255)));
         else send_reading(ut, 24'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: every divisor is zero, so all results flag an error
      send_reading(16'h0000, 24'h000000);
      send_reading(16'hffff, 24'hffffff);
      send_reading(16'd27898, 24'h5d2300);

      // nominal calibration, field extremes across oversampling settings
      for (int os = 0; os < 4; os++) begin
         wait_drained();
         load_calibration(NOM_A, NOM_B, NOM_C, 2'(os));
         send_reading(16'd27898, 24'h5d2300);
         send_reading(16'h0000, 24'h000000);
         send_reading(16'hffff, 24'hffffff);
         send_reading(16'h8000, 24'h800000);
         send_reading(16'd23153, 24'h7fffff);
      end

      // ac4 zero forces a zero pressure divisor
      wait_drained();
      load_calibration({NOM_A[63:16], 16'd0}, NOM_B, NOM_C, 2'd1);
      send_reading(16'd27898, 24'h5d2300);
      send_reading(16'hffff, 24'h000000);

      // all ones, and a temperature divisor cancelled by md
      wait_drained();
      load_calibration('1, '1, '1, 2'd3);
      send_reading(16'h0000, 24'hffffff);
      send_reading(16'hffff, 24'h000000);
      wait_drained();
      load_calibration(NOM_A, {16'd1, 16'd0, NOM_B[31:0]}, {16'd5, 16'hffff}, 2'd0);
      send_reading(16'h8000, 24'h123456);   // x1 = 1 cancels md = -1
      send_reading(16'h0000, 24'h654321);   // x1 = 0, divisor is md = -1
      wait_drained();
      load_calibration(NOM_A, {16'd1, 16'd0, NOM_B[31:0]}, {16'd5, 16'h0001}, 2'd2);
      send_reading(16'hffff, 24'habcdef);   // x1 = 1, x1 + md nonzero
      send_reading(16'h0000, 24'hfedcba);   // x1 = 0, md = 1

      // long receiver hold with the sender running flat out
      wait_drained();
      no_idle = 1;
      hold_rsp = 1;
      random_phase(250, 2'd0, 0);
      no_idle = 0;

      for (int ph = 0; ph < 12; ph++)
         random_phase(130, 2'(ph), ph % 3 == 2);

      no_idle = 1;
      random_phase(40, 2'd3, 0);
      no_idle = 0;

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d readings over %0d calibration phases, %0d results checked",
               items_sent, phase_count, results_seen);
      $display("%0d results carried the divide error flag", errors_seen);
      if (fail_count == 0 && results_seen == items_sent)
         $display("baro_sensor_compensation: match");
      else
         $display("baro_sensor_compensation: mismatch");
      $finish;
   end

   initial begin
      #(12 * 1_200_000);
      $display("baro_sensor_compensation: mismatch");
      $finish;
   end

endmodule

@@ baro_sensor_compensation.f @@
src/bsc_pkg.sv
src/bsc_if.sv
src/bsc_div.sv
src/baro_sensor_compensation.sv
tb/baro_sensor_compensation_checker.sv
tb/baro_sensor_compensation_tb.sv
